// ===== sv/hs_pkg.sv =====
// Shared types and constants for the heap sorter.
package hs_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int VALUE_W       = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic   gt;
    value_t max_val;
  } cmp_res_t;

endpackage

// ===== sv/hs_store.sv =====
// Value store: one write port, one read port with registered read data.
module hs_store #(
  parameter int DEPTH = hs_pkg::MAX_ITEMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  hs_pkg::value_t wr_data,
  input  logic [AW-1:0]  rd_addr,
  output hs_pkg::value_t rd_data
);
  import hs_pkg::*;

  value_t mem [DEPTH];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/hs_cmp.sv =====
// Shared signed comparator: challenger against incumbent, returns the larger.
module hs_cmp (
  input  hs_pkg::value_t   challenger,
  input  hs_pkg::value_t   incumbent,
  output hs_pkg::cmp_res_t res
);
  import hs_pkg::*;

  always_comb begin
    res.gt      = challenger > incumbent;
    res.max_val = res.gt ? challenger : incumbent;
  end

endmodule

// ===== sv/heap_sort_ascending.sv =====
// Heap sorter top level: batch load, in-place heapsort, ascending readout.
// Load: one item per cycle; the batch ends with the item flagged last.
// Sort: heap build then extraction through one store read port and one shared
//   comparator; each extraction pass runs S_X0 to S_X2, each heap level at most
//   S_SA to S_SC. Readout: one item per cycle while out_stall is low, after S_ORD.
// No item is taken during sort or readout. Reset clears control state only;
//   store contents are left as they are.
module heap_sort_ascending #(
  parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hs_pkg::value_t in_value,
  input  logic           in_last,
  output logic           out_valid,
  input  logic           out_stall,
  output hs_pkg::value_t out_value,
  output logic           out_last,
  output logic           out_overflow
);
  import hs_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = AW + 2;

  typedef enum logic [3:0] {
    S_LOAD, S_BRD, S_BCUR, S_SA, S_SB, S_SC, S_X0, S_X1, S_X2, S_ORD, S_OLD
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [AW-1:0] bi_r, bi_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] big_idx_r, big_idx_nxt;
  logic          sorting_r, sorting_nxt;
  value_t        cur_r, cur_nxt;
  value_t        big_val_r, big_val_nxt;
  logic          out_valid_r, out_valid_nxt;
  value_t        out_value_r, out_value_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  value_t        wr_data;
  logic [AW-1:0] rd_addr;
  value_t        rd_data;
  value_t        cmp_a, cmp_b;
  cmp_res_t      cmp_res;

  logic [IW-1:0] left_w, right_w;
  logic          left_ok, right_ok;
  logic          room;
  logic          decide, finish;
  logic [AW-1:0] dec_idx;
  value_t        dec_val;
  logic          slot_free, k_last;

  hs_store #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hs_cmp u_cmp (
    .challenger (cmp_a),
    .incumbent  (cmp_b),
    .res        (cmp_res)
  );

  assign left_w    = {1'b0, pos_r, 1'b1};
  assign right_w   = left_w + IW'(1);
  assign left_ok   = left_w < IW'(len_r);
  assign right_ok  = right_w < IW'(len_r);
  assign room      = count_r < CW'(MAX_ITEMS);
  assign slot_free = !out_valid_r || !out_stall;
  assign k_last    = CW'(k_r) == (n_r - CW'(1));

  assign cmp_a = rd_data;
  assign cmp_b = (state_r == S_SC) ? big_val_r : cur_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    len_nxt       = len_r;
    bi_nxt        = bi_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    big_idx_nxt   = big_idx_r;
    big_val_nxt   = big_val_r;
    sorting_nxt   = sorting_r;
    cur_nxt       = cur_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = cur_r;
    rd_addr       = pos_r;
    decide        = 1'b0;
    finish        = 1'b0;
    dec_idx       = pos_r;
    dec_val       = cur_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          wr_addr = count_r[AW-1:0];
          wr_data = in_value;
          if (room) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt       = count_r + CW'(room);
            len_nxt     = n_nxt;
            sorting_nxt = 1'b0;
            k_nxt       = '0;
            if (n_nxt < CW'(2)) begin
              state_nxt = S_ORD;
            end else begin
              bi_nxt    = AW'((n_nxt >> 1) - CW'(1));
              pos_nxt   = bi_nxt;
              state_nxt = S_BRD;
            end
          end
        end
      end
      S_BRD: begin
        state_nxt = S_BCUR;
      end
      S_BCUR: begin
        cur_nxt   = rd_data;
        state_nxt = S_SA;
      end
      S_SA: begin
        rd_addr = left_w[AW-1:0];
        if (left_ok) begin
          state_nxt = S_SB;
        end else begin
          decide = 1'b1;
        end
      end
      S_SB: begin
        rd_addr     = right_w[AW-1:0];
        big_val_nxt = cmp_res.max_val;
        big_idx_nxt = cmp_res.gt ? left_w[AW-1:0] : pos_r;
        if (right_ok) begin
          state_nxt = S_SC;
        end else begin
          decide  = 1'b1;
          dec_idx = big_idx_nxt;
          dec_val = big_val_nxt;
        end
      end
      S_SC: begin
        decide  = 1'b1;
        dec_idx = cmp_res.gt ? right_w[AW-1:0] : big_idx_r;
        dec_val = cmp_res.max_val;
      end
      S_X0: begin
        rd_addr   = j_r;
        state_nxt = S_X1;
      end
      S_X1: begin
        cur_nxt   = rd_data;
        rd_addr   = '0;
        state_nxt = S_X2;
      end
      S_X2: begin
        wr_en     = 1'b1;
        wr_addr   = j_r;
        wr_data   = rd_data;
        pos_nxt   = '0;
        len_nxt   = CW'(j_r);
        state_nxt = S_SA;
      end
      S_ORD: begin
        rd_addr   = k_r;
        state_nxt = S_OLD;
      end
      S_OLD: begin
        rd_addr = k_r;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_data;
          out_last_nxt  = k_last;
          out_ovf_nxt   = ovf_r;
          if (k_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt   = k_r + AW'(1);
            rd_addr = k_nxt;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase

    // one level of sift-down settled: move the hole or drop the value in
    if (decide) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      if (dec_idx == pos_r) begin
        wr_data = cur_r;
        finish  = 1'b1;
      end else begin
        wr_data   = dec_val;
        pos_nxt   = dec_idx;
        state_nxt = S_SA;
      end
    end

    if (finish) begin
      if (!sorting_r) begin
        if (bi_r != '0) begin
          bi_nxt    = bi_r - AW'(1);
          pos_nxt   = bi_nxt;
          state_nxt = S_BRD;
        end else begin
          sorting_nxt = 1'b1;
          j_nxt       = AW'(n_r - CW'(1));
          state_nxt   = S_X0;
        end
      end else if (j_r > AW'(1)) begin
        j_nxt     = j_r - AW'(1);
        state_nxt = S_X0;
      end else begin
        k_nxt     = '0;
        state_nxt = S_ORD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    len_r       <= len_nxt;
    bi_r        <= bi_nxt;
    j_r         <= j_nxt;
    pos_r       <= pos_nxt;
    k_r         <= k_nxt;
    big_idx_r   <= big_idx_nxt;
    big_val_r   <= big_val_nxt;
    sorting_r   <= sorting_nxt;
    cur_r       <= cur_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_stall     = state_r != S_LOAD;
  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_load_only_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && out_valid_r) |-> out_last_r)
    else $error("loading while a non-final item is still pending");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result item valid straight after reset");

  a_sift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SA || state_r == S_SB || state_r == S_SC) |-> CW'(pos_r) < len_r)
    else $error("sift position outside heap range");

endmodule
